[design/pd_charge_current_voltage_regulator_assert.svh]
// Assertion macros for the checker file of this block.
`ifndef PD_CHARGE_CURRENT_VOLTAGE_REGULATOR_ASSERT_SVH
`define PD_CHARGE_CURRENT_VOLTAGE_REGULATOR_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define PDCR_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pdcr assertion failed");

// Clocked assertion that is also checked during reset.
`define PDCR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pdcr assertion failed");

`endif

[design/pdcr_pkg.sv]
package pdcr_pkg;

  localparam int unsigned DataW     = 32;                // Q16.16 word
  localparam int unsigned QFrac     = 16;                // fraction bits
  localparam int unsigned MagW      = 32;                // multiplier operand magnitude
  localparam int unsigned MulDigitW = 4;                 // bits of b per cycle
  localparam int unsigned MulDigits = MagW / MulDigitW;  // digit steps per product
  localparam int unsigned DigCntW   = $clog2(MulDigits);
  localparam int unsigned ProdQW    = 2 * MagW + 1 - QFrac;  // signed scaled product
  localparam int unsigned CfgIdxW   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DESIRED_CURRENT = 3'd0,
    CFG_PROP_GAIN       = 3'd1,
    CFG_DERIV_GAIN      = 3'd2,
    CFG_INV_TIME_STEP   = 3'd3,
    CFG_VOLT_LOW        = 3'd4,
    CFG_VOLT_HIGH       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic            start;
    logic [MagW-1:0] a;
    logic [MagW-1:0] b;
    logic            neg;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [ProdQW-1:0] q;
  } mul_rsp_t;

endpackage

[design/pd_charge_current_voltage_regulator.sv]
// One item at a time: input is taken only while idle, and the four products
// run one after another through a single 4-bit-per-cycle multiplier.
// A finished result waits in the output register while the next item is taken.
// Reset (async, active low): held voltage, previous error and output valid clear,
// inverse time step resets to 1.0, other config to zero; item data is not reset.
module pd_charge_current_voltage_regulator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // [31:0] node_potential_high, [63:32] node_potential_low,
  // [95:64] battery_conductance, [127:96] battery_source_current
  input  logic [4*pdcr_pkg::DataW-1:0]   s_axis_tdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] regulated_voltage
  output logic [pdcr_pkg::DataW-1:0]     m_axis_tdata_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  input  logic                           cfg_we_i,
  input  logic [pdcr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pdcr_pkg::DataW-1:0]     cfg_data_i
);
  import pdcr_pkg::*;

  localparam int unsigned AccW = DataW + 19;  // holds held voltage plus two products

  typedef enum logic [3:0] {
    S_IDLE, S_A_GO, S_A_WAIT, S_ERR, S_B_GO, S_B_WAIT,
    S_C_GO, S_C_WAIT, S_D_GO, S_D_WAIT, S_CLAMP
  } state_e;

  // saturate to signed 32 bits: upper bits must all match the sign
  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [DataW-1:0] r;
    if (!v[AccW-1] && (|v[AccW-2:DataW-1])) begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end else if (v[AccW-1] && !(&v[AccW-2:DataW-1])) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // magnitude of a 33-bit value known to lie strictly within +-2^32
  function automatic logic [MagW-1:0] mag33(input logic signed [DataW:0] x);
    logic signed [DataW:0] n;
    n = -x;
    return x[DataW] ? n[MagW-1:0] : x[MagW-1:0];
  endfunction

  // configuration registers
  logic signed [DataW-1:0] desired_q, vlow_q, vhigh_q;
  logic        [DataW-1:0] kp_q, kd_q, its_q;

  // sequencer and state
  state_e                  state_q;
  logic signed [DataW-1:0] prev_err_q, ctrl_q;
  logic                    out_valid_q;

  // item data and intermediate results
  logic signed [DataW-1:0] vh_q, vl_q, cond_q, src_q;
  logic signed [DataW-1:0] cur_q, err_q, deriv_q, out_data_q;
  logic signed [AccW-1:0]  acc_q;

  logic signed [DataW:0]    diff, ediff;
  logic signed [ProdQW-1:0] mul_prod;
  logic signed [AccW-1:0]   cur_sum, err_sum, acc_first, acc_second;
  logic signed [DataW-1:0]  v_sat, v_clamp;
  logic                     in_xfer, out_free;
  mul_req_t                 mul_req;
  mul_rsp_t                 mul_rsp;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // ---------------------------------------------------------------------
  // Configuration writes; unknown indexes fall through untouched.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desired_q <= '0;
      kp_q      <= '0;
      kd_q      <= '0;
      its_q     <= DataW'(1) << QFrac;
      vlow_q    <= '0;
      vhigh_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DESIRED_CURRENT: desired_q <= cfg_data_i;
        CFG_PROP_GAIN:       kp_q      <= cfg_data_i;
        CFG_DERIV_GAIN:      kd_q      <= cfg_data_i;
        CFG_INV_TIME_STEP:   its_q     <= cfg_data_i;
        CFG_VOLT_LOW:        vlow_q    <= cfg_data_i;
        CFG_VOLT_HIGH:       vhigh_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Operand selection for the shared multiplier. Products in order:
  //   A: (high - low) * conductance  -> battery current
  //   B: (error - previous) * 1/dt   -> derivative
  //   C: Kp * error
  //   D: Kd * derivative
  // ---------------------------------------------------------------------
  assign diff  = (DataW+1)'(vh_q) - (DataW+1)'(vl_q);
  assign ediff = (DataW+1)'(err_q) - (DataW+1)'(prev_err_q);

  always_comb begin
    mul_req = '0;
    case (state_q)
      S_A_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = mag33(diff);
        mul_req.b     = mag33((DataW+1)'(cond_q));
        mul_req.neg   = diff[DataW] ^ cond_q[DataW-1];
      end
      S_B_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = mag33(ediff);
        mul_req.b     = its_q;
        mul_req.neg   = ediff[DataW];
      end
      S_C_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = kp_q;
        mul_req.b     = mag33((DataW+1)'(err_q));
        mul_req.neg   = err_q[DataW-1];
      end
      S_D_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = kd_q;
        mul_req.b     = mag33((DataW+1)'(deriv_q));
        mul_req.neg   = deriv_q[DataW-1];
      end
      default: mul_req = '0;
    endcase
  end

  pdcr_ser_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign mul_prod = mul_rsp.q;

  // sums; current and error saturate where they land, the control sum at the clamp
  assign cur_sum    = AccW'(mul_prod) + AccW'(src_q);
  assign err_sum    = AccW'(desired_q) - AccW'(cur_q);
  assign acc_first  = AccW'(ctrl_q) + AccW'(mul_prod);
  assign acc_second = acc_q + AccW'(mul_prod);
  assign v_sat      = sat32(acc_q);

  // high limit wins, so inverted limits give high above it and low below
  always_comb begin
    if (v_sat > vhigh_q) begin
      v_clamp = vhigh_q;
    end else if (v_sat < vlow_q) begin
      v_clamp = vlow_q;
    end else begin
      v_clamp = v_sat;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer, state held across items and output valid.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_err_q  <= '0;
      ctrl_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // in S_CLAMP the reload below owns the valid flag
      if (out_valid_q && m_axis_tready_i && (state_q != S_CLAMP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE:   if (in_xfer) state_q <= S_A_GO;
        S_A_GO:   state_q <= S_A_WAIT;
        S_A_WAIT: if (mul_rsp.done) state_q <= S_ERR;
        S_ERR:    state_q <= S_B_GO;
        S_B_GO: begin
          prev_err_q <= err_q;
          state_q    <= S_B_WAIT;
        end
        S_B_WAIT: if (mul_rsp.done) state_q <= S_C_GO;
        S_C_GO:   state_q <= S_C_WAIT;
        S_C_WAIT: if (mul_rsp.done) state_q <= S_D_GO;
        S_D_GO:   state_q <= S_D_WAIT;
        S_D_WAIT: if (mul_rsp.done) state_q <= S_CLAMP;
        S_CLAMP: begin
          // wait for the output register to free up
          if (out_free) begin
            ctrl_q      <= v_clamp;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // item data path
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          vh_q   <= s_axis_tdata_i[DataW-1:0];
          vl_q   <= s_axis_tdata_i[2*DataW-1:DataW];
          cond_q <= s_axis_tdata_i[3*DataW-1:2*DataW];
          src_q  <= s_axis_tdata_i[4*DataW-1:3*DataW];
        end
      end
      S_A_WAIT: if (mul_rsp.done) cur_q <= sat32(cur_sum);
      S_ERR:    err_q <= sat32(err_sum);
      S_B_WAIT: if (mul_rsp.done) deriv_q <= sat32(AccW'(mul_prod));
      S_C_WAIT: if (mul_rsp.done) acc_q <= acc_first;
      S_D_WAIT: if (mul_rsp.done) acc_q <= acc_second;
      S_CLAMP:  if (out_free) out_data_q <= v_clamp;
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

[design/pdcr_ser_mul.sv]
// Digit-serial magnitude multiplier, floor(+-a*b / 2^16).
module pdcr_ser_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdcr_pkg::mul_req_t req_i,
  output pdcr_pkg::mul_rsp_t rsp_o
);
  import pdcr_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mstate_e;

  mstate_e                  state_q, state_d;
  logic                     done_q, done_d;
  logic [DigCntW-1:0]       cnt_q, cnt_d;
  logic [MagW-1:0]          a_q, a_d, b_q, b_d, hi_q, hi_d, lo_q, lo_d;
  logic                     neg_q, neg_d;
  logic signed [ProdQW-1:0] q_q, q_d;
  logic [MagW+MulDigitW-1:0] step_sum;
  logic [2*MagW:0]          prod_s;

  // one partial product per cycle, low bits retire into lo
  assign step_sum = {{MulDigitW{1'b0}}, hi_q}
                  + (MagW+MulDigitW)'(a_q) * (MagW+MulDigitW)'(b_q[MulDigitW-1:0]);
  // negate before the shift: arithmetic shift gives floor
  assign prod_s   = neg_q ? -{1'b0, hi_q, lo_q} : {1'b0, hi_q, lo_q};

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    neg_d   = neg_q;
    q_d     = q_q;
    case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.a;
          b_d     = req_i.b;
          neg_d   = req_i.neg;
          hi_d    = '0;
          lo_d    = '0;
          cnt_d   = '0;
          state_d = M_RUN;
        end
      end
      M_RUN: begin
        hi_d  = step_sum[MagW+MulDigitW-1:MulDigitW];
        lo_d  = {step_sum[MulDigitW-1:0], lo_q[MagW-1:MulDigitW]};
        b_d   = b_q >> MulDigitW;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DigCntW'(MulDigits - 1)) begin
          state_d = M_FIX;
        end
      end
      M_FIX: begin
        q_d     = prod_s[2*MagW:QFrac];
        done_d  = 1'b1;
        state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    a_q   <= a_d;
    b_q   <= b_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    neg_q <= neg_d;
    q_q   <= q_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = q_q;

endmodule

[design/pdcr_checker.sv]
`include "pd_charge_current_voltage_regulator_assert.svh"

module pdcr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic [4*pdcr_pkg::DataW-1:0]   s_axis_tdata_i,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [pdcr_pkg::DataW-1:0]     m_axis_tdata_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic                           cfg_we_i,
  input logic [pdcr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [pdcr_pkg::DataW-1:0]     cfg_data_i
);

  logic in_xfer;

  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // a result waiting on a stall holds its data
  `PDCR_ASSERT_CLK(a_out_hold, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)))

  // once reset has been seen at an edge, nothing is offered
  `PDCR_ASSERT_ALWAYS(a_reset_quiet, clk_i, (!rst_ni |=> !m_axis_tvalid_o))

  // one item at a time: input closes right after a transfer
  `PDCR_ASSERT_CLK(a_busy_after_in, clk_i, rst_ni, (in_xfer |=> !s_axis_tready_o))

  // a new result never appears the cycle after an input transfer
  `PDCR_ASSERT_CLK(a_no_instant_result, clk_i, rst_ni, ($rose(m_axis_tvalid_o) |-> !$past(in_xfer)))

  // configuration is only written while the block is empty
  `PDCR_ASSERT_CLK(a_cfg_idle, clk_i, rst_ni, (cfg_we_i |-> s_axis_tready_o && !m_axis_tvalid_o))

endmodule

bind pd_charge_current_voltage_regulator pdcr_checker u_pdcr_checker (.*);
